@@ design/bptc_pkg.sv @@
// Shared types, widths and constants of the barometer compensation pipeline.
package bptc_pkg;

   typedef enum logic [2:0] {
      CSR_AC1_AC2 = 3'd0,
      CSR_AC3     = 3'd1,
      CSR_AC4     = 3'd2,
      CSR_AC5     = 3'd3,
      CSR_AC6     = 3'd4,
      CSR_B1_B2   = 3'd5,
      CSR_MC      = 3'd6,
      CSR_MD      = 3'd7
   } csr_index_type;

   localparam int CSR_DW = 32;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [15:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic [19:0]        pressure_pa;
      logic               divide_fault;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic [15:0]        ac4;
      logic [15:0]        ac5;
      logic [15:0]        ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
   } cal_type;

   // divider shapes: temperature divide (27 / 20 bit), pressure divide (32 / 17 bit)
   localparam int DIV1_NW = 27;
   localparam int DIV1_DW = 20;
   localparam int DIV2_NW = 32;
   localparam int DIV2_DW = 17;

   typedef struct packed {
      logic               neg;
      logic               fault;
      logic signed [18:0] x1;
      logic [15:0]        up;
   } td_side_type;

   typedef struct packed {
      logic               dbl;
      logic               fault;
      logic signed [15:0] temp;
   } pd_side_type;

   localparam int TD_SIDE_W = $bits(td_side_type);
   localparam int PD_SIDE_W = $bits(pd_side_type);

   localparam int FRONT_STAGES = 3;
   localparam int MID_STAGES   = 10;
   localparam int BACK_STAGES  = 5;
   localparam int LATENCY = FRONT_STAGES + DIV1_NW + MID_STAGES + DIV2_NW + BACK_STAGES;

   localparam int                 C_B6_OFFSET = 4000;
   localparam logic [31:0]        C_X3_BIAS   = 32'd32768;
   localparam logic [15:0]        C_B7_SCALE  = 16'd50000;
   localparam logic [11:0]        C_P_K1      = 12'd3038;
   localparam logic [12:0]        C_P_K2      = 13'd7357;
   localparam logic signed [12:0] C_P_K3      = 13'sd3791;
   localparam logic [19:0]        PRESS_MAX   = 20'd1048575;

   localparam logic [31:0]        RST_AC1_AC2 = 32'd26804152;
   localparam logic signed [15:0] RST_AC3     = -16'sd14383;
   localparam logic [15:0]        RST_AC4     = 16'd32741;
   localparam logic [15:0]        RST_AC5     = 16'd32757;
   localparam logic [15:0]        RST_AC6     = 16'd23153;
   localparam logic [31:0]        RST_B1_B2   = 32'd405667844;
   localparam logic signed [15:0] RST_MC      = -16'sd8711;
   localparam logic signed [15:0] RST_MD      = 16'sd2868;

endpackage

@@ design/bptc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per register stage.
module bptc_div #(
   parameter int NW = 32,
   parameter int DW = 17,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          vld_ff  [NW];
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] nq_ff   [NW];
   logic [DW-1:0] den_ff  [NW];
   logic [SW-1:0] side_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic          vld_src;
      logic [DW-1:0] rem_src;
      logic [NW-1:0] nq_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign nq_src   = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign nq_src   = nq_ff[i-1];
         assign den_src  = den_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      // shift in the next numerator bit, subtract where it fits
      assign trial  = {rem_src, nq_src[NW-1]};
      assign ge     = trial >= {1'b0, den_src};
      assign rem_in = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
      assign nq_in  = {nq_src[NW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_src;
         end
         rem_ff[i]  <= rem_in;
         nq_ff[i]   <= nq_in;
         den_ff[i]  <= den_src;
         side_ff[i] <= side_src;
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = nq_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

@@ design/bptc_front.sv @@
// Temperature front end: raw offset, gain product and divide operand setup.
module bptc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  bptc_pkg::req_type                  in_item,
   input  bptc_pkg::cal_type                  cal,
   output logic                               out_valid,
   output logic [bptc_pkg::DIV1_NW-1:0]       out_num,
   output logic [bptc_pkg::DIV1_DW-1:0]       out_den,
   output bptc_pkg::td_side_type              out_side
);
   import bptc_pkg::*;

   logic                  v1_ff, v2_ff, v3_ff;
   logic signed [16:0]    d_ff, d_in;
   logic [15:0]           up1_ff, up2_ff;
   logic signed [33:0]    prod_ff, prod_in;
   logic [DIV1_NW-1:0]    num_ff, num_in;
   logic [DIV1_DW-1:0]    den_ff, den_in;
   td_side_type           side_ff, side_in;

   always_comb begin
      logic signed [18:0]         x1;
      logic signed [DIV1_DW-1:0]  den_s;
      logic signed [DIV1_NW-1:0]  num_s;
      d_in    = $signed({1'b0, in_item.raw_temperature}) - $signed({1'b0, cal.ac6});
      prod_in = 34'(d_ff) * 34'($signed({1'b0, cal.ac5}));
      x1      = 19'(prod_ff >>> 15);
      den_s   = DIV1_DW'(x1) + DIV1_DW'(cal.md);
      num_s   = DIV1_NW'(cal.mc) <<< 11;
      // divide magnitudes, restore sign afterwards
      num_in  = num_s[DIV1_NW-1] ? DIV1_NW'(-num_s) : DIV1_NW'(num_s);
      den_in  = den_s[DIV1_DW-1] ? DIV1_DW'(-den_s) : DIV1_DW'(den_s);
      side_in.neg   = num_s[DIV1_NW-1] ^ den_s[DIV1_DW-1];
      side_in.fault = (den_s == '0);
      side_in.x1    = x1;
      side_in.up    = up2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      d_ff    <= d_in;
      up1_ff  <= in_item.raw_pressure;
      prod_ff <= prod_in;
      up2_ff  <= up1_ff;
      num_ff  <= num_in;
      den_ff  <= den_in;
      side_ff <= side_in;
   end

   assign out_valid = v3_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

@@ design/bptc_mid.sv @@
// Pressure middle section: b5 to b3, b4 and b7, with pressure divide setup.
module bptc_mid (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [bptc_pkg::DIV1_NW-1:0]       in_quo,
   input  bptc_pkg::td_side_type              in_side,
   input  bptc_pkg::cal_type                  cal,
   output logic                               out_valid,
   output logic [bptc_pkg::DIV2_NW-1:0]       out_num,
   output logic [bptc_pkg::DIV2_DW-1:0]       out_den,
   output bptc_pkg::pd_side_type              out_side
);
   import bptc_pkg::*;

   typedef struct packed {
      logic               fault;
      logic [15:0]        up;
      logic signed [15:0] temp;
   } carry_type;

   logic               vld_ff [MID_STAGES];
   carry_type          c_ff   [MID_STAGES];
   carry_type          c_in   [MID_STAGES];

   logic signed [28:0] b5_ff, b5_in;
   logic signed [29:0] b6_ff, b6_in;
   logic [14:0]        mh_ff, mh_in, ml_ff, ml_in;
   logic [29:0]        hh_ff, hh_in, hl_ff, hl_in, ll_ff, ll_in;
   logic signed [45:0] a2_ff [4];
   logic signed [45:0] a3_ff [4];
   logic signed [45:0] a2_in, a3_in;
   logic [47:0]        sq_ff, sq_in;
   logic signed [40:0] p2l_ff, p2l_in, p2h_ff, p2h_in, p1l_ff, p1l_in, p1h_ff, p1h_in;
   logic signed [64:0] b2sq_ff, b2sq_in, b1sq_ff, b1sq_in;
   logic signed [56:0] v_ff, v_in;
   logic signed [50:0] x3r_ff, x3r_in;
   logic [31:0]        b3lo_ff, b3lo_in, w_ff, w_in;
   logic [16:0]        b4_ff, b4_in, b4d_ff;
   logic [31:0]        b7pre_ff, b7pre_in, b7_ff, b7_in;
   logic signed [15:0] temp_in;

   always_comb begin
      logic signed [27:0] x2;
      logic signed [29:0] tw;
      logic [29:0]        mag;
      logic [59:0]        sqf;
      logic signed [56:0] b3f;
      logic signed [48:0] x3b;
      logic [47:0]        b4p;
      logic [47:0]        b7p;

      // M1: signed quotient, b5
      x2    = $signed(28'(in_quo));
      x2    = in_side.neg ? -x2 : x2;
      b5_in = 29'(in_side.x1) + 29'(x2);

      // M2: b6 and its magnitude halves, saturated temperature
      b6_in = 30'(b5_ff) - 30'(C_B6_OFFSET);
      mag   = b6_in[29] ? 30'(-b6_in) : 30'(b6_in);
      mh_in = mag[29:15];
      ml_in = mag[14:0];
      tw    = (30'(b5_ff) + 30'sd8) >>> 4;
      if (tw > 30'sd32767) begin
         temp_in = 16'sd32767;
      end else if (tw < -30'sd32768) begin
         temp_in = -16'sd32768;
      end else begin
         temp_in = 16'(tw);
      end

      // M3: square partial products, linear terms
      hh_in = 30'(mh_ff) * 30'(mh_ff);
      hl_in = 30'(mh_ff) * 30'(ml_ff);
      ll_in = 30'(ml_ff) * 30'(ml_ff);
      a2_in = 46'(cal.ac2) * 46'(b6_ff);
      a3_in = 46'(cal.ac3) * 46'(b6_ff);

      // M4: b6 squared, shifted down by 12
      sqf   = (60'(hh_ff) << 30) + (60'(hl_ff) << 16) + 60'(ll_ff);
      sq_in = sqf[59:12];

      // M5: coefficient times square, in two halves
      p2l_in = 41'(cal.b2) * $signed(41'(sq_ff[23:0]));
      p2h_in = 41'(cal.b2) * $signed(41'(sq_ff[47:24]));
      p1l_in = 41'(cal.b1) * $signed(41'(sq_ff[23:0]));
      p1h_in = 41'(cal.b1) * $signed(41'(sq_ff[47:24]));

      // M6: join halves
      b2sq_in = (65'(p2h_ff) <<< 24) + 65'(p2l_ff);
      b1sq_in = (65'(p1h_ff) <<< 24) + 65'(p1l_ff);

      // M7: b3 numerator and x3 sum
      v_in   = (57'(cal.ac1) <<< 2) + 57'(b2sq_ff >>> 11) + 57'(a2_ff[3] >>> 11) + 57'sd2;
      x3r_in = 51'(a3_ff[3] >>> 13) + 51'(b1sq_ff >>> 16) + 51'sd2;

      // M8: b3 rounds toward zero; biased x3 wraps at 32 bits
      b3f     = v_ff[56] ? ((v_ff + 57'sd3) >>> 2) : (v_ff >>> 2);
      b3lo_in = b3f[31:0];
      x3b     = 49'(x3r_ff >>> 2);
      w_in    = 32'(x3b) + C_X3_BIAS;

      // M9: b4 and the pressure offset
      b4p      = 48'(cal.ac4) * 48'(w_ff);
      b4_in    = b4p[31:15];
      b7pre_in = 32'(c_ff[7].up) - b3lo_ff;

      // M10: b7
      b7p   = 48'(b7pre_ff) * 48'(C_B7_SCALE);
      b7_in = b7p[31:0];

      c_in[0].fault = in_side.fault;
      c_in[0].up    = in_side.up;
      c_in[0].temp  = '0;
      for (int k = 1; k < MID_STAGES; k++) begin
         c_in[k] = c_ff[k-1];
      end
      c_in[1].temp  = temp_in;
      c_in[MID_STAGES-1].fault = c_ff[MID_STAGES-2].fault | (b4_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MID_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < MID_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      for (int k = 0; k < MID_STAGES; k++) begin
         c_ff[k] <= c_in[k];
      end
      b5_ff    <= b5_in;
      b6_ff    <= b6_in;
      mh_ff    <= mh_in;
      ml_ff    <= ml_in;
      hh_ff    <= hh_in;
      hl_ff    <= hl_in;
      ll_ff    <= ll_in;
      a2_ff[0] <= a2_in;
      a3_ff[0] <= a3_in;
      for (int k = 1; k < 4; k++) begin
         a2_ff[k] <= a2_ff[k-1];
         a3_ff[k] <= a3_ff[k-1];
      end
      sq_ff    <= sq_in;
      p2l_ff   <= p2l_in;
      p2h_ff   <= p2h_in;
      p1l_ff   <= p1l_in;
      p1h_ff   <= p1h_in;
      b2sq_ff  <= b2sq_in;
      b1sq_ff  <= b1sq_in;
      v_ff     <= v_in;
      x3r_ff   <= x3r_in;
      b3lo_ff  <= b3lo_in;
      w_ff     <= w_in;
      b4_ff    <= b4_in;
      b7pre_ff <= b7pre_in;
      b4d_ff   <= b4_ff;
      b7_ff    <= b7_in;
   end

   // top bit of b7 set: divide b7 and double later, else divide 2*b7
   assign out_valid      = vld_ff[MID_STAGES-1];
   assign out_num        = b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
   assign out_den        = b4d_ff;
   assign out_side.dbl   = b7_ff[31];
   assign out_side.fault = c_ff[MID_STAGES-1].fault;
   assign out_side.temp  = c_ff[MID_STAGES-1].temp;

endmodule

@@ design/bptc_back.sv @@
// Pressure back end: quadratic correction, clamping and the result register.
module bptc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [bptc_pkg::DIV2_NW-1:0]       in_quo,
   input  bptc_pkg::pd_side_type              in_side,
   output logic                               out_valid,
   output bptc_pkg::rsp_type                  out_item
);
   import bptc_pkg::*;

   localparam int NC = BACK_STAGES - 1;

   logic               vld_ff [BACK_STAGES];
   pd_side_type        c_ff   [NC];
   logic [31:0]        p_ff   [NC];
   logic [31:0]        p_in;
   logic [47:0]        m_ff, m_in;
   logic [44:0]        y_ff [2];
   logic [44:0]        y_in;
   logic [35:0]        mh3_ff, mh3_in, ml3_ff, ml3_in;
   logic signed [45:0] s_ff, s_in;
   rsp_type            item_ff, item_in;

   always_comb begin
      logic [59:0]        x1f;
      logic signed [45:0] x2;
      logic signed [46:0] pn;

      // B1: undo the halving trick of the divide
      p_in   = in_side.dbl ? {in_quo[30:0], 1'b0} : in_quo;
      // B2: (p >> 8) squared and the linear term
      m_in   = 48'(p_ff[0][31:8]) * 48'(p_ff[0][31:8]);
      y_in   = 45'(p_ff[0]) * 45'(C_P_K2);
      // B3: square times its coefficient, in two halves
      mh3_in = 36'(m_ff[47:24]) * 36'(C_P_K1);
      ml3_in = 36'(m_ff[23:0]) * 36'(C_P_K1);
      // B4: correction sum
      x1f    = (60'(mh3_ff) << 24) + 60'(ml3_ff);
      x2     = (-$signed(46'(y_ff[1]))) >>> 16;
      s_in   = $signed(46'(x1f[59:16])) + x2 + 46'(C_P_K3);
      // B5: apply, clamp, zero on fault
      pn     = $signed(47'(p_ff[NC-1])) + 47'(s_ff >>> 4);
      item_in.divide_fault = c_ff[NC-1].fault;
      if (c_ff[NC-1].fault) begin
         item_in.temperature_tenths = '0;
         item_in.pressure_pa        = '0;
      end else begin
         item_in.temperature_tenths = c_ff[NC-1].temp;
         if (pn < 47'sd0) begin
            item_in.pressure_pa = '0;
         end else if (pn > $signed(47'(PRESS_MAX))) begin
            item_in.pressure_pa = PRESS_MAX;
         end else begin
            item_in.pressure_pa = pn[19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < BACK_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < BACK_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      c_ff[0] <= in_side;
      p_ff[0] <= p_in;
      for (int k = 1; k < NC; k++) begin
         c_ff[k] <= c_ff[k-1];
         p_ff[k] <= p_ff[k-1];
      end
      m_ff    <= m_in;
      y_ff[0] <= y_in;
      y_ff[1] <= y_ff[0];
      mh3_ff  <= mh3_in;
      ml3_ff  <= ml3_in;
      s_ff    <= s_in;
      item_ff <= item_in;
   end

   assign out_valid = vld_ff[BACK_STAGES-1];
   assign out_item  = item_ff;

endmodule

@@ design/baro_temp_pressure_compensation.sv @@
// Every accepted item gives one rsp_valid strobe after passing the front end, temperature divider,
// middle section, pressure divider and back end in that order; nothing in the path stalls.
// Throughput: one item per cycle outside reset; the two restoring dividers (27 and 32 stages, one
// quotient bit each) and the multiply stages are fully pipelined.
// busy is high only while reset is held; the result strobe cannot be held off.
// Reset (synchronous, active high) empties the pipeline and loads the factory coefficients.
module baro_temp_pressure_compensation (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bptc_pkg::req_type         req_item,
   output logic                      rsp_valid,
   output bptc_pkg::rsp_type         rsp_item,
   input  logic                      csr_we,
   input  bptc_pkg::csr_index_type   csr_index,
   input  logic [bptc_pkg::CSR_DW-1:0] csr_data
);
   import bptc_pkg::*;

   logic [31:0] cal_ac1_ac2_ff, cal_b1_b2_ff;
   logic [15:0] cal_ac3_ff, cal_ac4_ff, cal_ac5_ff, cal_ac6_ff, cal_mc_ff, cal_md_ff;
   cal_type     cal;
   logic        accept;

   logic                 fr_valid;
   logic [DIV1_NW-1:0]   fr_num;
   logic [DIV1_DW-1:0]   fr_den;
   td_side_type          fr_side;
   logic                 d1_valid;
   logic [DIV1_NW-1:0]   d1_quo;
   td_side_type          d1_side;
   logic                 md_valid;
   logic [DIV2_NW-1:0]   md_num;
   logic [DIV2_DW-1:0]   md_den;
   pd_side_type          md_side;
   logic                 d2_valid;
   logic [DIV2_NW-1:0]   d2_quo;
   pd_side_type          d2_side;

   // Nothing is in flight across reset, so hold off new items only then.
   assign busy   = reset;
   assign accept = start & ~busy;

   // Calibration registers: write at any edge with csr_we high, narrow ones keep the low half.
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ac1_ac2_ff <= RST_AC1_AC2;
         cal_ac3_ff     <= RST_AC3;
         cal_ac4_ff     <= RST_AC4;
         cal_ac5_ff     <= RST_AC5;
         cal_ac6_ff     <= RST_AC6;
         cal_b1_b2_ff   <= RST_B1_B2;
         cal_mc_ff      <= RST_MC;
         cal_md_ff      <= RST_MD;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AC1_AC2: cal_ac1_ac2_ff <= csr_data;
            CSR_AC3:     cal_ac3_ff     <= csr_data[15:0];
            CSR_AC4:     cal_ac4_ff     <= csr_data[15:0];
            CSR_AC5:     cal_ac5_ff     <= csr_data[15:0];
            CSR_AC6:     cal_ac6_ff     <= csr_data[15:0];
            CSR_B1_B2:   cal_b1_b2_ff   <= csr_data;
            CSR_MC:      cal_mc_ff      <= csr_data[15:0];
            CSR_MD:      cal_md_ff      <= csr_data[15:0];
            default:     cal_md_ff      <= cal_md_ff;
         endcase
      end
   end

   // Unpack the paired coefficients; signed ones are two's complement.
   always_comb begin
      cal.ac1 = $signed(cal_ac1_ac2_ff[31:16]);
      cal.ac2 = $signed(cal_ac1_ac2_ff[15:0]);
      cal.ac3 = $signed(cal_ac3_ff);
      cal.ac4 = cal_ac4_ff;
      cal.ac5 = cal_ac5_ff;
      cal.ac6 = cal_ac6_ff;
      cal.b1  = $signed(cal_b1_b2_ff[31:16]);
      cal.b2  = $signed(cal_b1_b2_ff[15:0]);
      cal.mc  = $signed(cal_mc_ff);
      cal.md  = $signed(cal_md_ff);
   end

   // Temperature front end: x1 and the x1 + md divisor, three stages.
   bptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .cal       (cal),
      .out_valid (fr_valid),
      .out_num   (fr_num),
      .out_den   (fr_den),
      .out_side  (fr_side)
   );

   // mc * 2048 / (x1 + md) on magnitudes; x1, up and the fault ride alongside.
   bptc_div #(
      .NW (DIV1_NW),
      .DW (DIV1_DW),
      .SW (TD_SIDE_W)
   ) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_side   (fr_side),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // b5 through b7 and b4, ten stages; temperature is settled here and carried on.
   bptc_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_valid),
      .in_quo    (d1_quo),
      .in_side   (d1_side),
      .cal       (cal),
      .out_valid (md_valid),
      .out_num   (md_num),
      .out_den   (md_den),
      .out_side  (md_side)
   );

   // Pressure divide by b4.
   bptc_div #(
      .NW (DIV2_NW),
      .DW (DIV2_DW),
      .SW (PD_SIDE_W)
   ) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (md_valid),
      .in_num    (md_num),
      .in_den    (md_den),
      .in_side   (md_side),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   // Quadratic correction and the result register.
   bptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d2_valid),
      .in_quo    (d2_quo),
      .in_side   (d2_side),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted item gave no result after the pipeline latency");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted item");

   a_fault_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.divide_fault) |->
         (rsp_item.temperature_tenths == 16'sd0 && rsp_item.pressure_pa == 20'd0))
      else $error("divide fault with non-zero results");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the barometer temperature and pressure compensation pipeline.
module tb_top;
   import bptc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_type       req_item;
   logic          rsp_valid;
   rsp_type       rsp_item;
   logic          csr_we;
   csr_index_type csr_index;
   logic [CSR_DW-1:0] csr_data;

   // testbench copy of the calibration registers, indexed like the CSR map
   logic [31:0] cal_shadow [8];
   rsp_type     expected_readings [$];
   int          error_count;
   int          quiet_cycles;
   bit          gaps_on;

   baro_temp_pressure_compensation i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Predict one reading from the shadowed calibration, datasheet integer scheme.
   // Shifts of signed longints are arithmetic; divisions truncate toward zero.
   function automatic rsp_type compensate(req_type it);
      longint ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint x1, x2, x3, b3, b5, b6, sq, t, p;
      logic [63:0] prod;
      logic [31:0] b4, b7, q;
      rsp_type r;
      r = '0;
      r.divide_fault = 1'b1;
      ut  = longint'(it.raw_temperature);
      up  = longint'(it.raw_pressure);
      ac1 = longint'($signed(cal_shadow[CSR_AC1_AC2][31:16]));
      ac2 = longint'($signed(cal_shadow[CSR_AC1_AC2][15:0]));
      ac3 = longint'($signed(cal_shadow[CSR_AC3][15:0]));
      ac4 = longint'(cal_shadow[CSR_AC4][15:0]);
      ac5 = longint'(cal_shadow[CSR_AC5][15:0]);
      ac6 = longint'(cal_shadow[CSR_AC6][15:0]);
      b1  = longint'($signed(cal_shadow[CSR_B1_B2][31:16]));
      b2  = longint'($signed(cal_shadow[CSR_B1_B2][15:0]));
      mc  = longint'($signed(cal_shadow[CSR_MC][15:0]));
      md  = longint'($signed(cal_shadow[CSR_MD][15:0]));

      // temperature path; a zero divisor faults the whole reading
      x1 = ((ut - ac6) * ac5) >>> 15;
      if (x1 + md == 0) return r;
      x2 = (mc * 2048) / (x1 + md);
      b5 = x1 + x2;

      // pressure path
      b6 = b5 - 4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = (ac1 * 4 + x3 + 2) / 4;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      prod = (x3 + 32768) * ac4;
      b4 = prod[31:0] >> 15;
      if (b4 == 32'd0) return r;
      b7 = 32'(up - b3) * 32'd50000;
      if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
      else                    q = (b7 / b4) * 32'd2;
      p = longint'(q);

      // quadratic correction, then clamp
      x1 = (p >>> 8) * (p >>> 8);
      x1 = (x1 * 3038) >>> 16;
      x2 = (-7357 * p) >>> 16;
      p  = p + ((x1 + x2 + 3791) >>> 4);
      if (p < 0) p = 0;
      if (p > longint'(PRESS_MAX)) p = longint'(PRESS_MAX);

      t = (b5 + 8) >>> 4;
      if (t > 32767)  t = 32767;
      if (t < -32768) t = -32768;

      r.temperature_tenths = 16'(t);
      r.pressure_pa        = 20'(p);
      r.divide_fault       = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Compare each strobed reading with the oldest prediction; sample mid-cycle.
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("reading with nothing expected");
         end else begin
            want = expected_readings.pop_front();
            if (rsp_item.temperature_tenths !== want.temperature_tenths)
               report_mismatch($sformatf("temperature_tenths %0d, want %0d",
                  rsp_item.temperature_tenths, want.temperature_tenths));
            if (rsp_item.pressure_pa !== want.pressure_pa)
               report_mismatch($sformatf("pressure_pa %0d, want %0d",
                  rsp_item.pressure_pa, want.pressure_pa));
            if (rsp_item.divide_fault !== want.divide_fault)
               report_mismatch($sformatf("divide_fault %0b, want %0b",
                  rsp_item.divide_fault, want.divide_fault));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(negedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one item and hold it until accepted; start stays high for back-to-back items.
   task automatic send_item(input logic [15:0] ut, input logic [15:0] up);
      req_type it;
      it.raw_temperature = ut;
      it.raw_pressure    = up;
      start    <= 1'b1;
      req_item <= it;
      do @(negedge clock); while (busy);
      @(posedge clock);
      expected_readings.push_back(compensate(it));
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Drop start and wait until every predicted reading has arrived.
   task automatic drain;
      start <= 1'b0;
      wait (expected_readings.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // Write all eight calibration registers back to back while idle.
   task automatic load_cal(input logic [31:0] v [8]);
      drain();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= v[i];
         @(posedge clock);
         cal_shadow[i] = (i == CSR_AC1_AC2 || i == CSR_B1_B2) ? v[i] : {16'd0, v[i][15:0]};
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void factory_cal(output logic [31:0] v [8]);
      v[CSR_AC1_AC2] = RST_AC1_AC2;
      v[CSR_AC3]     = {16'd0, RST_AC3};
      v[CSR_AC4]     = {16'd0, RST_AC4};
      v[CSR_AC5]     = {16'd0, RST_AC5};
      v[CSR_AC6]     = {16'd0, RST_AC6};
      v[CSR_B1_B2]   = RST_B1_B2;
      v[CSR_MC]      = {16'd0, RST_MC};
      v[CSR_MD]      = {16'd0, RST_MD};
   endfunction

   // Mostly plausible readings around a typical operating point, some fully random.
   task automatic send_random_item;
      logic [15:0] ut, up;
      if ($urandom_range(0, 3) == 0) begin
         ut = 16'($urandom);
         up = 16'($urandom);
      end else begin
         ut = 16'($urandom_range(19000, 37000));
         up = 16'($urandom_range(12000, 36000));
      end
      send_item(ut, up);
   endtask

   task automatic test_factory;
      logic [31:0] v [8];
      factory_cal(v);
      load_cal(v);
      send_item(16'd27898, 16'd23843);
      send_item(16'd0, 16'd0);
      send_item(16'hFFFF, 16'hFFFF);
      send_item(16'd0, 16'hFFFF);
      send_item(16'hFFFF, 16'd0);
      send_item(16'hAAAA, 16'h5555);
      send_item(16'h5555, 16'hAAAA);
   endtask

   // Temperature divisor zero: ac5 = 0 makes x1 zero, md = 0 completes it.
   task automatic test_temperature_fault;
      logic [31:0] v [8];
      factory_cal(v);
      v[CSR_AC5] = 32'd0;
      v[CSR_MD]  = 32'd0;
      load_cal(v);
      send_item(16'd27898, 16'd23843);
      send_item(16'hFFFF, 16'd0);
   endtask

   // Pressure divisor zero: ac4 = 0 forces b4 to zero.
   task automatic test_pressure_fault;
      logic [31:0] v [8];
      factory_cal(v);
      v[CSR_AC4] = 32'd0;
      load_cal(v);
      send_item(16'd27898, 16'd23843);
      send_item(16'd0, 16'hFFFF);
   endtask

   // Divisor of one with extreme mc drives temperature past both rails.
   task automatic test_temperature_saturation;
      logic [31:0] v [8];
      factory_cal(v);
      v[CSR_AC5] = 32'd0;
      v[CSR_MD]  = 32'd1;
      v[CSR_MC]  = 32'h0000_8000;
      load_cal(v);
      send_item(16'd27898, 16'd23843);
      send_item(16'hFFFF, 16'hFFFF);
      v[CSR_MC]  = 32'h0000_7FFF;
      load_cal(v);
      send_item(16'd27898, 16'd23843);
      send_item(16'd0, 16'd0);
   endtask

   task automatic test_extreme_cal;
      logic [31:0] v [8];
      logic [31:0] pat [3];
      pat[0] = 32'hFFFF_FFFF;
      pat[1] = 32'h8000_8000;
      pat[2] = 32'h7FFF_7FFF;
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 8; i++) v[i] = pat[k];
         load_cal(v);
         send_item(16'd0, 16'hFFFF);
         send_item(16'hFFFF, 16'd0);
      end
   endtask

   // Random calibrations: most near factory values, a quarter fully random.
   task automatic test_random_cal(input int phases, input int per_phase);
      logic [31:0] v [8];
      for (int ph = 0; ph < phases; ph++) begin
         factory_cal(v);
         if ($urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 8; i++) v[i] = $urandom;
         end else begin
            for (int i = 0; i < 8; i++) begin
               v[i][15:0] = v[i][15:0] + 16'($urandom_range(0, 2000)) - 16'd1000;
               if (i == CSR_AC1_AC2 || i == CSR_B1_B2)
                  v[i][31:16] = v[i][31:16] + 16'($urandom_range(0, 2000)) - 16'd1000;
            end
         end
         load_cal(v);
         gaps_on = $urandom_range(0, 2) != 0;
         for (int n = 0; n < per_phase; n++) begin
            send_random_item();
            // hold the sender once until the pipeline is empty
            if (ph == 0 && n == per_phase / 2) drain();
         end
      end
   endtask

   // Final stretch at full rate, no idling.
   task automatic test_full_rate;
      logic [31:0] v [8];
      factory_cal(v);
      load_cal(v);
      gaps_on = 1'b0;
      repeat (250) send_random_item();
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_AC1_AC2;
      csr_data    = '0;
      error_count = 0;
      quiet_cycles = 0;
      gaps_on     = 1'b1;
      for (int i = 0; i < 8; i++) cal_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_factory();
      test_temperature_fault();
      test_pressure_fault();
      test_temperature_saturation();
      test_extreme_cal();
      test_random_cal(15, 110);
      test_full_rate();

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
